>>> hdl/icph_pkg.sv
// ----------------------------------------------------------------------------
// icph_pkg
// Shared types and constants for the Internet checksum block with TCP and
// UDP pseudo-header support.
// ----------------------------------------------------------------------------
`default_nettype none

package icph_pkg;

  localparam int unsigned WordW = 16;
  localparam int unsigned AddrW = 32;
  localparam int unsigned OpW   = 2;

  typedef enum logic [OpW-1:0] {
    OP_PLAIN = 2'd0,
    OP_TCP   = 2'd1,
    OP_UDP   = 2'd2
  } op_e;

  localparam logic [WordW-1:0] PROTO_TCP_WORD = 16'h0006;
  localparam logic [WordW-1:0] PROTO_UDP_WORD = 16'h0011;
  localparam logic [WordW-1:0] PAD_MASK       = 16'hFF00;

  typedef struct packed {
    logic [WordW-1:0] data_word;
    logic             first_word;
    logic             last_word;
    logic             single_byte;
    logic             clear_word;
    logic [OpW-1:0]   operation;
    logic [AddrW-1:0] source_address;
    logic [AddrW-1:0] dest_address;
    logic [WordW-1:0] segment_length;
  } item_t;

endpackage

`default_nettype wire

>>> hdl/icph_contrib.sv
// ----------------------------------------------------------------------------
// icph_contrib
// Folded ones'-complement contribution of one beat: the masked data word
// plus, on a first word of a TCP or UDP packet, the pseudo-header.
// ----------------------------------------------------------------------------
`default_nettype none

module icph_contrib (
  input  icph_pkg::item_t            item_i,
  output logic [icph_pkg::WordW-1:0] contrib_o
);
  import icph_pkg::*;

  localparam int unsigned SumW = WordW + 3;

  logic [WordW-1:0] word;
  logic [WordW-1:0] proto;
  logic             pseudo;
  logic [SumW-1:0]  sum;
  logic [WordW:0]   fold1;
  logic [WordW:0]   fold2;

  always_comb begin
    pseudo = 1'b0;
    proto  = PROTO_TCP_WORD;
    unique case (op_e'(item_i.operation))
      OP_TCP: begin
        pseudo = item_i.first_word;
        proto  = PROTO_TCP_WORD;
      end
      OP_UDP: begin
        pseudo = item_i.first_word;
        proto  = PROTO_UDP_WORD;
      end
      default: begin
        pseudo = 1'b0;
        proto  = PROTO_TCP_WORD;
      end
    endcase
  end

  always_comb begin
    if (item_i.clear_word) begin
      word = '0;
    end else if (item_i.last_word && item_i.single_byte) begin
      word = item_i.data_word & PAD_MASK;
    end else begin
      word = item_i.data_word;
    end
  end

  always_comb begin
    sum = SumW'(word);
    if (pseudo) begin
      sum = sum
          + SumW'(item_i.source_address[AddrW-1:WordW])
          + SumW'(item_i.source_address[WordW-1:0])
          + SumW'(item_i.dest_address[AddrW-1:WordW])
          + SumW'(item_i.dest_address[WordW-1:0])
          + SumW'(proto)
          + SumW'(item_i.segment_length);
    end
    fold1 = (WordW+1)'(sum[WordW-1:0]) + (WordW+1)'(sum[SumW-1:WordW]);
    fold2 = (WordW+1)'(fold1[WordW-1:0]) + (WordW+1)'(fold1[WordW]);
  end

  assign contrib_o = fold2[WordW-1:0];

endmodule

`default_nettype wire

>>> hdl/icph_accum.sv
// ----------------------------------------------------------------------------
// icph_accum
// Running ones'-complement sum with end-around carry and the result
// register holding the inverted checksum until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module icph_accum (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic                       first_i,
  input  logic                       last_i,
  input  logic [icph_pkg::WordW-1:0] contrib_i,
  output logic                       busy_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [icph_pkg::WordW-1:0] checksum_value_o
);
  import icph_pkg::*;

  logic [WordW-1:0] sum_q, sum_d;
  logic [WordW-1:0] base;
  logic [WordW:0]   raw;
  logic [WordW-1:0] acc;
  logic             vld_q, vld_d;
  logic [WordW-1:0] res_q, res_d;

  always_comb begin
    base  = first_i ? '0 : sum_q;
    raw   = (WordW+1)'(base) + (WordW+1)'(contrib_i);
    acc   = raw[WordW-1:0] + WordW'(raw[WordW]);
    sum_d = sum_q;
    vld_d = vld_q && !out_ready_i;
    res_d = res_q;
    if (step_i) begin
      sum_d = last_i ? '0 : acc;
      if (last_i) begin
        vld_d = 1'b1;
        res_d = ~acc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      vld_q <= 1'b0;
    end else begin
      sum_q <= sum_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign busy_o           = vld_q && !out_ready_i;
  assign out_valid_o      = vld_q;
  assign checksum_value_o = res_q;

endmodule

`default_nettype wire

>>> hdl/internet_checksum_pseudo_header_top.sv
// ----------------------------------------------------------------------------
// internet_checksum_pseudo_header_top
// Internet checksum over a stream of 16-bit words with optional TCP/UDP
// pseudo-header; emits the inverted sum on the last word of a packet.
// ----------------------------------------------------------------------------
// A beat passes the input register, then its checksum the output register.
// Throughput: one word per cycle while no last word waits on a held result.
// Backpressure: a last word waits in the input register while a result is
//   still held; other words keep flowing.
// Reset: clears running sum and valid flags; no clearing pass.
`default_nettype none

module internet_checksum_pseudo_header_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [icph_pkg::WordW-1:0] data_word_i,
  input  logic                       first_word_i,
  input  logic                       last_word_i,
  input  logic                       single_byte_i,
  input  logic                       clear_word_i,
  input  logic [icph_pkg::OpW-1:0]   operation_i,
  input  logic [icph_pkg::AddrW-1:0] source_address_i,
  input  logic [icph_pkg::AddrW-1:0] dest_address_i,
  input  logic [icph_pkg::WordW-1:0] segment_length_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [icph_pkg::WordW-1:0] checksum_value_o
);
  import icph_pkg::*;

  item_t            item_q, item_d;
  logic             vld_q, vld_d;
  logic             step;
  logic             busy;
  logic             in_fire;
  logic [WordW-1:0] contrib;

  assign step       = vld_q && !(item_q.last_word && busy);
  assign in_ready_o = !vld_q || step;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    item_d = item_q;
    vld_d  = vld_q && !step;
    if (in_fire) begin
      vld_d                 = 1'b1;
      item_d.data_word      = data_word_i;
      item_d.first_word     = first_word_i;
      item_d.last_word      = last_word_i;
      item_d.single_byte    = single_byte_i;
      item_d.clear_word     = clear_word_i;
      item_d.operation      = operation_i;
      item_d.source_address = source_address_i;
      item_d.dest_address   = dest_address_i;
      item_d.segment_length = segment_length_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  icph_contrib u_contrib (
    .item_i    (item_q),
    .contrib_o (contrib)
  );

  icph_accum u_accum (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (step),
    .first_i          (item_q.first_word),
    .last_i           (item_q.last_word),
    .contrib_i        (contrib),
    .busy_o           (busy),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .checksum_value_o (checksum_value_o)
  );

endmodule

`default_nettype wire

>>> tb/internet_checksum_pseudo_header_checker.sv
// ----------------------------------------------------------------------------
// Internet checksum pseudo-header checker
// Watches the word and checksum channels of the checksum block. It keeps its
// own ones'-complement running sum for every accepted word and queues the
// inverted sum on each last word. Each accepted checksum beat is compared
// with the oldest queued value. Reports the mismatch count and the number of
// checksums still owed.
// ----------------------------------------------------------------------------
module internet_checksum_pseudo_header_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  logic [icph_pkg::WordW-1:0] data_word_i,
  input  logic                       first_word_i,
  input  logic                       last_word_i,
  input  logic                       single_byte_i,
  input  logic                       clear_word_i,
  input  logic [icph_pkg::OpW-1:0]   operation_i,
  input  logic [icph_pkg::AddrW-1:0] source_address_i,
  input  logic [icph_pkg::AddrW-1:0] dest_address_i,
  input  logic [icph_pkg::WordW-1:0] segment_length_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  logic [icph_pkg::WordW-1:0] checksum_value_i,
  output int                         error_count_o,
  output int                         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import icph_pkg::*;

  logic [WordW-1:0] packet_sum;
  logic [WordW-1:0] expected_checksums[$];
  int               mismatch_count;

  function automatic logic [WordW-1:0] oc_add(logic [WordW-1:0] a, logic [WordW-1:0] b);
    logic [WordW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[WordW-1:0] + {{(WordW-1){1'b0}}, s[WordW]};
  endfunction

  task automatic absorb_word();
    logic [WordW-1:0] acc;
    logic [WordW-1:0] word;
    op_e              op;
    acc  = packet_sum;
    word = data_word_i;
    op   = op_e'(operation_i);
    if (first_word_i) begin
      acc = '0;
      if (op == OP_TCP || op == OP_UDP) begin
        acc = oc_add(acc, source_address_i[31:16]);
        acc = oc_add(acc, source_address_i[15:0]);
        acc = oc_add(acc, dest_address_i[31:16]);
        acc = oc_add(acc, dest_address_i[15:0]);
        acc = oc_add(acc, (op == OP_TCP) ? PROTO_TCP_WORD : PROTO_UDP_WORD);
        acc = oc_add(acc, segment_length_i);
      end
    end
    if (clear_word_i) begin
      word = '0;
    end else if (last_word_i && single_byte_i) begin
      word = word & PAD_MASK;
    end
    acc = oc_add(acc, word);
    if (last_word_i) begin
      expected_checksums.push_back(~acc);
      packet_sum = '0;
    end else begin
      packet_sum = acc;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      packet_sum = '0;
      expected_checksums.delete();
      mismatch_count = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_checksums.size() == 0) begin
          $error("checksum_value beat with no expected result: actual %h", checksum_value_i);
          mismatch_count++;
        end else if (checksum_value_i !== expected_checksums[0]) begin
          $error("checksum_value mismatch: expected %h, actual %h",
                 expected_checksums[0], checksum_value_i);
          mismatch_count++;
          void'(expected_checksums.pop_front());
        end else begin
          void'(expected_checksums.pop_front());
        end
      end
      if (in_valid_i && in_ready_i) begin
        absorb_word();
      end
    end
    error_count_o = mismatch_count;
    pending_o     = expected_checksums.size();
  end

endmodule

>>> tb/tb_internet_checksum_pseudo_header_top.sv
// ----------------------------------------------------------------------------
// Internet checksum pseudo-header testbench
// Drives packet word streams into the checksum block: a directed set for the
// corner cases, then random TCP, UDP, plain and unused-op packets, some with no
// first word, mixed with loose words. Both sides idle at random, and the checksum
// side holds off once for a long stretch to back the block up. The checker does
// the prediction and comparison; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_internet_checksum_pseudo_header_top;
  timeunit 1ns;
  timeprecision 1ps;

  import icph_pkg::*;

  localparam logic [OpW-1:0] OP_UNUSED   = 2'd3;
  localparam int             WORD_TARGET = 1350;
  localparam int             HOLD_AT     = 40;
  localparam int             HOLD_CYCLES = 400;
  localparam int             DRAIN_WAIT  = 10;
  localparam int             CYCLE_LIMIT = 200000;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  item_t            beat;
  logic             out_valid;
  logic             out_ready;
  logic [WordW-1:0] checksum_value;
  int               error_count;
  int               pending;
  int               cycle_count;
  int               words_sent;
  int               results_taken;
  bit               sender_idles;
  bit               receiver_idles;

  internet_checksum_pseudo_header_top u_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .data_word_i      (beat.data_word),
    .first_word_i     (beat.first_word),
    .last_word_i      (beat.last_word),
    .single_byte_i    (beat.single_byte),
    .clear_word_i     (beat.clear_word),
    .operation_i      (beat.operation),
    .source_address_i (beat.source_address),
    .dest_address_i   (beat.dest_address),
    .segment_length_i (beat.segment_length),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .checksum_value_o (checksum_value)
  );

  internet_checksum_pseudo_header_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .data_word_i      (beat.data_word),
    .first_word_i     (beat.first_word),
    .last_word_i      (beat.last_word),
    .single_byte_i    (beat.single_byte),
    .clear_word_i     (beat.clear_word),
    .operation_i      (beat.operation),
    .source_address_i (beat.source_address),
    .dest_address_i   (beat.dest_address),
    .segment_length_i (beat.segment_length),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .checksum_value_i (checksum_value),
    .error_count_o    (error_count),
    .pending_o        (pending)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [WordW-1:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return '1;
      1:       return '0;
      default: return WordW'($urandom);
    endcase
  endfunction

  function automatic logic [AddrW-1:0] rand_addr();
    case ($urandom_range(0, 9))
      0:       return '1;
      1:       return '0;
      default: return AddrW'($urandom);
    endcase
  endfunction

  task automatic send_beat(input item_t it);
    int gap;
    if (words_sent % 50 == 0) begin
      sender_idles = ($urandom_range(0, 3) != 0);
    end
    gap = sender_idles ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    beat     <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_fields(input logic [WordW-1:0] data, input logic first,
                             input logic last, input logic single, input logic clear,
                             input logic [OpW-1:0] op, input logic [AddrW-1:0] src,
                             input logic [AddrW-1:0] dst, input logic [WordW-1:0] len);
    item_t it;
    it.data_word      = data;
    it.first_word     = first;
    it.last_word      = last;
    it.single_byte    = single;
    it.clear_word     = clear;
    it.operation      = op;
    it.source_address = src;
    it.dest_address   = dst;
    it.segment_length = len;
    send_beat(it);
  endtask

  task automatic send_packet(input int n_words, input logic [OpW-1:0] op,
                             input bit with_first);
    for (int i = 0; i < n_words; i++) begin
      send_fields(rand_word(), with_first && i == 0, i == n_words - 1,
                  $urandom_range(0, 3) == 0, $urandom_range(0, 9) == 0,
                  (i == 0) ? op : OpW'($urandom), rand_addr(), rand_addr(), rand_word());
    end
  endtask

  initial begin
    int pick;
    int n_words;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    beat        = '0;
    cycle_count = 0;
    words_sent  = 0;
    sender_idles = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // one-word packets at the extremes
    send_fields(16'hFFFF, 1, 1, 0, 0, OP_PLAIN, '0, '0, '0);
    send_fields(16'h0000, 1, 1, 0, 0, OP_PLAIN, '1, '1, '1);
    send_fields(16'hFFFF, 1, 1, 0, 0, OP_TCP, '1, '1, '1);
    send_fields(16'hABFF, 1, 1, 1, 0, OP_UDP, 32'h12345678, 32'h9ABCDEF0, 16'h0008);
    // UDP with zero pseudo-header, odd length
    send_fields(16'h1234, 1, 0, 0, 0, OP_UDP, '0, '0, '0);
    send_fields(16'hABCD, 0, 1, 1, 0, OP_PLAIN, '1, '1, '1);
    // unused op, ignored fields mid-packet, cleared words
    send_fields(16'h8000, 1, 0, 0, 0, OP_UNUSED, 32'hC0A80001, 32'hC0A800FF, 16'h0014);
    send_fields(16'h8000, 0, 0, 1, 0, OP_TCP, '1, '1, '1);
    send_fields(16'hFFFF, 0, 0, 0, 1, OP_UDP, '1, '1, '1);
    send_fields(16'h5A5A, 0, 1, 1, 1, OP_PLAIN, '0, '0, '0);
    // words with no first word
    send_fields(16'h0102, 0, 0, 0, 0, OP_TCP, '1, '1, '1);
    send_fields(16'h0304, 0, 1, 0, 0, OP_PLAIN, '0, '0, '0);
    // TCP header-like packet with end-around carry
    send_fields(16'h4500, 1, 0, 0, 0, OP_TCP, 32'h0A000001, 32'h0A000002, 16'h0028);
    send_fields(16'hFFFF, 0, 0, 0, 0, OP_PLAIN, '0, '0, '0);
    send_fields(16'hFFFF, 0, 0, 0, 0, OP_PLAIN, '0, '0, '0);
    send_fields(16'h00FF, 0, 1, 1, 0, OP_PLAIN, '0, '0, '0);

    while (words_sent < WORD_TARGET) begin
      pick    = $urandom_range(0, 99);
      n_words = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 8);
      if (pick < 80) begin
        send_packet(n_words, OpW'($urandom), 1'b1);
      end else if (pick < 88) begin
        send_packet(n_words, OpW'($urandom), 1'b0);
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_fields(rand_word(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), OpW'($urandom),
                      rand_addr(), rand_addr(), rand_word());
        end
      end
    end

    @(negedge clk) in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // checksum side: random stalls plus one long hold-off to fill the block
  initial begin
    int gap;
    out_ready      = 1'b0;
    results_taken  = 0;
    receiver_idles = 1'b1;
    @(posedge rst_n);
    forever begin
      if (results_taken % 25 == 0) begin
        receiver_idles = ($urandom_range(0, 3) != 0);
      end
      gap = receiver_idles ? $urandom_range(0, 5) : 0;
      if (results_taken == HOLD_AT) begin
        gap = HOLD_CYCLES;
      end
      if (gap > 0) begin
        @(negedge clk) out_ready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk) out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
      results_taken++;
    end
  end

endmodule
